/* sv/lcg_sample_histogram_assert.svh */
// Assertion macros shared by the lcg_sample_histogram modules.
`ifndef LCG_SAMPLE_HISTOGRAM_ASSERT_SVH
`define LCG_SAMPLE_HISTOGRAM_ASSERT_SVH

// Checked out of reset only.
`define LSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define LSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/lsh_pkg.sv */
// Shared constants and types for the LCG sample histogram.
package lsh_pkg;

  localparam int SAMPLE_W     = 31;
  localparam int COUNT_W      = 32;
  localparam int BIN_W        = 4;
  localparam int FUNC_W       = 2;
  localparam int BINS_W       = 7;
  localparam int BINS_DEFAULT = 10;
  localparam int QUEUE_DEPTH  = 2;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [SAMPLE_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] MULT_RESET = 31'd397204094;
  localparam logic [SAMPLE_W-1:0] INC_RESET  = 31'd0;
  localparam logic [SAMPLE_W-1:0] SEED_RESET = 31'd12458978;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_MULT = 2'd0;
  localparam logic [1:0] REG_INC  = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_GEN     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_GEN     = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] sel;
    logic             hit;
  } cmd_t;

endpackage

/* sv/lsh_front.sv */
// Request decoder and two-entry command queue.
module lsh_front #(
  parameter int BINS = lsh_pkg::BINS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lsh_pkg::FUNC_W-1:0] in_func,
  input  logic [lsh_pkg::BIN_W-1:0]  in_bin_select,
  output logic                       q_valid,
  output lsh_pkg::cmd_t              q_cmd,
  input  logic                       q_pop
);

  `include "lcg_sample_histogram_assert.svh"

  localparam int DEPTH = lsh_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BW7   = lsh_pkg::BINS_W;

  lsh_pkg::cmd_t    ent_r [DEPTH];
  lsh_pkg::cmd_t    cmd;
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;

  always_comb begin
    cmd.sel = in_bin_select;
    cmd.hit = BW7'(in_bin_select) < BW7'(BINS);
    unique case (in_func)
      lsh_pkg::FUNC_GEN:     cmd.op = lsh_pkg::OP_GEN;
      lsh_pkg::FUNC_READ:    cmd.op = lsh_pkg::OP_READ;
      lsh_pkg::FUNC_RESTART: cmd.op = lsh_pkg::OP_RESTART;
      default:               cmd.op = lsh_pkg::OP_NOP;
    endcase
  end

  assign in_stall  = (count_r == CNT_W'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign q_valid   = (count_r != '0);
  assign q_cmd     = ent_r[rd_ptr_r];
  assign count_nxt = count_r + CNT_W'(push) - CNT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cmd;
    end
  end

  `LSH_ASSERT(a_q_bound, count_r <= CNT_W'(DEPTH), "queue count over depth")
  `LSH_ASSERT(a_q_grow, (push && !q_pop) |=> (count_r == $past(count_r) + CNT_W'(1)), "queue lost a request")
  `LSH_ASSERT(a_q_pop_nonempty, q_pop |-> (count_r != '0), "pop from empty queue")

endmodule

/* sv/lsh_back.sv */
// Execution unit: LCG step, Mersenne reduction, binning and counter memory.
module lsh_back #(
  parameter int BINS = lsh_pkg::BINS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lsh_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  input  logic [lsh_pkg::SAMPLE_W-1:0] mult,
  input  logic [lsh_pkg::SAMPLE_W-1:0] inc,
  input  logic [lsh_pkg::SAMPLE_W-1:0] seed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsh_pkg::SAMPLE_W-1:0] out_sample,
  output logic [lsh_pkg::BIN_W-1:0]    out_bin,
  output logic [lsh_pkg::COUNT_W-1:0]  out_bin_count
);

  `include "lcg_sample_histogram_assert.svh"

  localparam int SW = lsh_pkg::SAMPLE_W;
  localparam int CW = lsh_pkg::COUNT_W;
  localparam int NW = lsh_pkg::BIN_W;
  localparam int BW = $clog2(BINS);
  localparam int QW = $clog2(BINS + 1);
  localparam int YW = SW + QW;
  localparam int PW = 2 * SW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_MOD  = 6'b000100,
    S_BIN  = 6'b001000,
    S_UPD  = 6'b010000,
    S_RD   = 6'b100000
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  logic [SW-1:0]   cur_r;
  logic [PW-1:0]   p_r;
  logic [SW+1:0]   t_r;
  logic [BW-1:0]   idx_r;
  logic [NW-1:0]   sel_r;
  logic [CW-1:0]   rd_r;
  logic            vhit_r;
  logic [BINS-1:0] vld_r;
  logic [CW-1:0]   cnt_mem [BINS];

  logic            out_valid_r;
  logic [SW-1:0]   out_sample_r;
  logic [NW-1:0]   out_bin_r;
  logic [CW-1:0]   out_count_r;

  logic            out_free;
  logic            mem_we;
  logic            out_load;
  logic [SW-1:0]   seed_mod;
  logic [PW:0]     s_sum;
  logic [SW+1:0]   t_sum;
  logic [SW:0]     u_sum;
  logic [SW:0]     u_red;
  logic [YW-1:0]   y_prod;
  logic [QW-1:0]   q_lo;
  logic [SW:0]     r_sum;
  logic [QW-1:0]   q_fix;
  logic [BW-1:0]   bin_idx;
  logic [BW-1:0]   rd_addr;
  logic [CW-1:0]   cnt_cur;
  logic [CW-1:0]   cnt_new;
  logic [SW-1:0]   res_sample;
  logic [NW-1:0]   res_bin;
  logic [CW-1:0]   res_count;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign mem_we   = (state_r == S_UPD) && out_free;
  assign seed_mod = (seed == lsh_pkg::LCG_MOD) ? '0 : seed;

  // a*x + c folded twice around 2^31 - 1, then one conditional subtract
  assign s_sum = (PW+1)'(p_r) + (PW+1)'(inc);
  assign t_sum = (SW+2)'(s_sum[SW-1:0]) + (SW+2)'(s_sum[PW:SW]);
  assign u_sum = (SW+1)'(t_r[SW-1:0]) + (SW+1)'(t_r[SW+1:SW]);
  assign u_red = (u_sum >= (SW+1)'(lsh_pkg::LCG_MOD)) ?
                 u_sum - (SW+1)'(lsh_pkg::LCG_MOD) : u_sum;

  // floor(BINS*x / M) with a single correction step
  assign y_prod  = YW'(BINS) * YW'(cur_r);
  assign q_lo    = y_prod[YW-1:SW];
  assign r_sum   = (SW+1)'(y_prod[SW-1:0]) + (SW+1)'(q_lo);
  assign q_fix   = q_lo + QW'(r_sum >= (SW+1)'(lsh_pkg::LCG_MOD));
  assign bin_idx = (q_fix >= QW'(BINS)) ? BW'(BINS - 1) : BW'(q_fix);

  assign rd_addr = (state_r == S_BIN) ? bin_idx : BW'(q_cmd.sel);
  assign cnt_cur = vhit_r ? rd_r : '0;
  assign cnt_new = (cnt_cur == lsh_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + CW'(1);

  always_comb begin
    state_nxt  = state_r;
    out_load   = 1'b0;
    res_sample = cur_r;
    res_bin    = '0;
    res_count  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            lsh_pkg::OP_GEN: begin
              state_nxt = S_RED;
            end
            lsh_pkg::OP_READ: begin
              res_bin = q_cmd.sel;
              if (q_cmd.hit) begin
                state_nxt = S_RD;
              end else begin
                out_load = 1'b1;
              end
            end
            lsh_pkg::OP_RESTART: begin
              res_sample = seed_mod;
              out_load   = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RED: state_nxt = S_MOD;
      S_MOD: state_nxt = S_BIN;
      S_BIN: state_nxt = S_UPD;
      S_UPD: begin
        res_bin   = NW'(idx_r);
        res_count = cnt_new;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        res_bin   = sel_r;
        res_count = cnt_cur;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= lsh_pkg::SEED_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (q_pop && q_cmd.op == lsh_pkg::OP_RESTART) begin
        cur_r <= seed_mod;
        vld_r <= '0;
      end else if (state_r == S_MOD) begin
        cur_r <= SW'(u_red);
      end
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= PW'(mult) * PW'(cur_r);
    t_r <= t_sum;
    if (state_r == S_BIN) begin
      idx_r <= bin_idx;
    end
    if (q_pop) begin
      sel_r <= q_cmd.sel;
    end
    if (out_load) begin
      out_sample_r <= res_sample;
      out_bin_r    <= res_bin;
      out_count_r  <= res_count;
    end
  end

  // read data is held while a result waits on out_stall
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[idx_r] <= cnt_new;
    end
    if (q_pop || state_r == S_BIN) begin
      rd_r   <= cnt_mem[rd_addr];
      vhit_r <= vld_r[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_bin       = out_bin_r;
  assign out_bin_count = out_count_r;

  `LSH_ASSERT(a_cur_below_mod, cur_r != lsh_pkg::LCG_MOD, "generator state reached modulus")
  `LSH_ASSERT(a_bin_range, (state_r == S_UPD) |-> (idx_r <= BW'(BINS - 1)), "bin index out of range")
  `LSH_ASSERT(a_upd_result, mem_we |=> out_valid_r, "counter update without result")
  `LSH_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "reset did not idle")

endmodule

/* sv/lcg_sample_histogram.sv */
// Top level: LCG modulo 2^31-1 with a per-bin sample histogram.
//
// Requests enter on in_valid/in_stall with in_func and in_bin_select; one
// result leaves per request on out_valid/out_stall. A request is taken at an
// edge with valid high and stall low. in_func: generate, read bin, restart.
// multiplier, increment and seed sit on the APB port at 0x0, 0x4 and 0x8.
// Requests pass through a two-entry queue; in_stall rises when it is full.
// A generate passes through S_RED, S_MOD, S_BIN and S_UPD, a read of a valid
// bin through S_RD; restart, out-of-range read and unused codes load their
// result straight from S_IDLE. Generate holds the execution unit through
// multiply, two folds, bin compute and counter read-modify-write on the
// counter memory, and a valid read through S_RD; no new request is taken
// until they end. Other requests go one per cycle while out_stall is low.
// Reset loads the register defaults, sets the sample to the seed default,
// marks every counter zero and empties the queue and output register.
// While out_stall is high the result holds, the execution unit finishes into
// it no further, and the queue fills and then stalls the input.
module lcg_sample_histogram #(
  parameter int BINS = lsh_pkg::BINS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsh_pkg::FUNC_W-1:0]   in_func,
  input  logic [lsh_pkg::BIN_W-1:0]    in_bin_select,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsh_pkg::SAMPLE_W-1:0] out_sample,
  output logic [lsh_pkg::BIN_W-1:0]    out_bin,
  output logic [lsh_pkg::COUNT_W-1:0]  out_bin_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsh_pkg::ADDR_W-1:0]   paddr,
  input  logic [lsh_pkg::DATA_W-1:0]   pwdata,
  output logic [lsh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int SW = lsh_pkg::SAMPLE_W;
  localparam int DW = lsh_pkg::DATA_W;
  localparam int AW = lsh_pkg::ADDR_W;

  logic [SW-1:0] mult_r;
  logic [SW-1:0] inc_r;
  logic [SW-1:0] seed_r;
  logic          cfg_we;
  logic [1:0]    cfg_idx;
  logic          q_valid;
  logic          q_pop;
  lsh_pkg::cmd_t q_cmd;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= lsh_pkg::MULT_RESET;
      inc_r  <= lsh_pkg::INC_RESET;
      seed_r <= lsh_pkg::SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lsh_pkg::REG_MULT: mult_r <= pwdata[SW-1:0];
        lsh_pkg::REG_INC:  inc_r  <= pwdata[SW-1:0];
        lsh_pkg::REG_SEED: seed_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lsh_pkg::REG_MULT: prdata = DW'(mult_r);
      lsh_pkg::REG_INC:  prdata = DW'(inc_r);
      lsh_pkg::REG_SEED: prdata = DW'(seed_r);
      default:           prdata = '0;
    endcase
  end

  lsh_front #(
    .BINS(BINS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_bin_select(in_bin_select),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  lsh_back #(
    .BINS(BINS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .mult         (mult_r),
    .inc          (inc_r),
    .seed         (seed_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_bin      (out_bin),
    .out_bin_count(out_bin_count)
  );

endmodule

/* test/tb_lcg_sample_histogram.sv */
// Testbench for lcg_sample_histogram: directed and random requests, predicted results, APB setup.
module tb_lcg_sample_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import lsh_pkg::*;

  localparam int NBINS = BINS_DEFAULT;
  localparam longint unsigned MOD_M = 64'h7FFF_FFFF;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]    bin;
    logic [COUNT_W-1:0]  count;
  } hist_result_t;

  class lcg_hist_tracker;
    logic [SAMPLE_W-1:0] mult, inc, seed, value;
    logic [COUNT_W-1:0]  counts[NBINS];
    hist_result_t        expected_results[$];
    int                  errors;

    function new();
      mult = MULT_RESET;
      inc = INC_RESET;
      seed = SEED_RESET;
      value = SEED_RESET;
      foreach (counts[k]) counts[k] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_MULT: mult = data[SAMPLE_W-1:0];
        REG_INC:  inc  = data[SAMPLE_W-1:0];
        REG_SEED: seed = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the generator / histogram and queue the expected result.
    function void note_request(op_t op, logic [BIN_W-1:0] sel);
      hist_result_t    r;
      longint unsigned nxt;
      int unsigned     idx;
      r.bin = '0;
      r.count = '0;
      case (op)
        OP_GEN: begin
          nxt = (longint'(mult) * longint'(value) + longint'(inc)) % MOD_M;
          value = nxt[SAMPLE_W-1:0];
          idx = int'((longint'(NBINS) * nxt) / MOD_M);
          if (idx >= NBINS) idx = NBINS - 1;
          if (counts[idx] != COUNT_MAX) counts[idx] = counts[idx] + 1;
          r.bin = idx[BIN_W-1:0];
          r.count = counts[idx];
        end
        OP_READ: begin
          r.bin = sel;
          if (sel < NBINS) r.count = counts[sel];
        end
        OP_RESTART: begin
          value = SAMPLE_W'(longint'(seed) % MOD_M);
          foreach (counts[k]) counts[k] = '0;
        end
        default: ;
      endcase
      r.sample = value;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] sample, logic [BIN_W-1:0] bin,
                               logic [COUNT_W-1:0] count);
      hist_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: sample=%0d bin=%0d count=%0d", sample, bin, count);
        return;
      end
      e = expected_results.pop_front();
      if (sample !== e.sample || bin !== e.bin || count !== e.count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: exp sample=%0d bin=%0d count=%0d, got sample=%0d bin=%0d count=%0d",
                   e.sample, e.bin, e.count, sample, bin, count);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [BIN_W-1:0]    in_bin_select = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample;
  logic [BIN_W-1:0]    out_bin;
  logic [COUNT_W-1:0]  out_bin_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bit gaps_on = 1'b1;
  lcg_hist_tracker tracker = new();

  lcg_sample_histogram uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_bin_select(in_bin_select),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .out_bin(out_bin), .out_bin_count(out_bin_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_result(out_sample, out_bin, out_bin_count);
      if (in_valid && !in_stall) tracker.note_request(op_t'(in_func), in_bin_select);
    end
  end

  task automatic send_request(input op_t op, input logic [BIN_W-1:0] sel);
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_bin_select <= sel;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) send_request(OP_GEN, BIN_W'($urandom_range(0, 15)));
    else if (r < 85)
      send_request(OP_READ, BIN_W'($urandom_range(0, 99) < 80 ? $urandom_range(0, NBINS - 1)
                                                             : $urandom_range(0, 15)));
    else if (r < 92) send_request(OP_RESTART, BIN_W'($urandom_range(0, 15)));
    else send_request(OP_NOP, BIN_W'($urandom_range(0, 15)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  task automatic set_generator(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] c,
                               input logic [DATA_W-1:0] s);
    write_reg(REG_MULT, m);
    write_reg(REG_INC, c);
    write_reg(REG_SEED, s);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: empty bins, out-of-range reads, unused code
    send_request(OP_READ, 4'd0);
    send_request(OP_READ, 4'd9);
    send_request(OP_GEN, 4'd0);
    send_request(OP_GEN, 4'd15);
    send_request(OP_GEN, 4'd5);
    send_request(OP_READ, 4'd15);
    send_request(OP_READ, 4'd10);
    send_request(OP_NOP, 4'd15);
    send_request(OP_READ, 4'd3);
    send_request(OP_RESTART, 4'd7);
    send_request(OP_GEN, 4'd0);

    // all-ones registers: values equal to the modulus, seed reduces to 0
    wait_drained();
    set_generator(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_RESTART, 4'd0);
    send_request(OP_GEN, 4'd0);
    send_request(OP_READ, 4'd0);

    // identity step from the top value lands in the last bin
    wait_drained();
    set_generator(32'd1, 32'd0, 32'd2147483646);
    send_request(OP_RESTART, 4'd0);
    send_request(OP_GEN, 4'd0);
    send_request(OP_GEN, 4'd0);
    send_request(OP_READ, 4'd9);

    wait_drained();
    set_generator(32'd0, 32'd0, 32'd0);
    send_request(OP_RESTART, 4'd0);
    send_request(OP_GEN, 4'd0);
    send_request(OP_READ, 4'd0);

    wait_drained();
    set_generator(32'd2147483646, 32'd2147483646, 32'd1);
    send_request(OP_RESTART, 4'd0);
    send_request(OP_GEN, 4'd0);
    send_request(OP_GEN, 4'd0);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      if (p == 0) set_generator(DATA_W'(MULT_RESET), DATA_W'(INC_RESET), DATA_W'(SEED_RESET));
      else set_generator($urandom(), $urandom(), $urandom());
      gaps_on = (p != 1);
      send_request(OP_RESTART, 4'd0);
      repeat (150) send_random();
    end
    gaps_on = 1'b0;
    wait_drained();

    if (tracker.errors == 0) begin
      $display("lcg_sample_histogram regression: pass");
    end else begin
      $display("lcg_sample_histogram regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("lcg_sample_histogram regression: fail");
    $finish;
  end

endmodule
